// File: sv/bounded_ordered_list_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded ordered list engine
// Clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ORDERED_LIST_ENGINE_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_ASSERT_SVH

// check cons in the same cycle as ante
`define BOLE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define BOLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bole_pkg.sv
// ----------------------------------------------------------------------------
// bole_pkg
// Sizes, codes, state and command types shared by the list engine modules.
// ----------------------------------------------------------------------------
package bole_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = CW + 1;
  localparam int DW    = 32;

  typedef enum logic [2:0] {
    OP_PUSH_TAIL = 3'd0,
    OP_PUSH_HEAD = 3'd1,
    OP_POP_HEAD  = 3'd2,
    OP_POP_TAIL  = 3'd3,
    OP_DELETE    = 3'd4,
    OP_CONTAINS  = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_SCAN,
    S_MOVE,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_HEAD,
    RD_TAIL,
    RD_NEXT,
    RD_NEXT2
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    push_tail;
    logic    push_head;
    logic    pop_head;
    logic    pop_tail;
    rd_sel_t rd_sel;
    logic    pos_clr;
    logic    pos_inc;
    logic    move_wr;
    logic    drop_head;
    logic    occ_dec;
    logic    set_found;
    logic    set_full;
    logic    set_empty;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       full;
    logic       empty;
    logic       match;
    logic       scan_last;
    logic       move_last;
    logic       pos_zero;
    logic       out_busy;
  } dp_status_t;

  // ring slot at offset ofs from base, ofs below DEPTH
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [SW-1:0] ofs);
    logic [SW-1:0] sum;
    sum = SW'(base) + ofs;
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

endpackage

// File: sv/bounded_ordered_list_engine.sv
// Pushes, unused opcodes and pops on an empty list pass from accept through
// execute to done; other pops pass through a read state before done.
// Delete and contains on a non-empty list also pass through scan (and move).
// One item at a time; the scan and compaction walk the store one entry per cycle,
// and the result waits in done while the output stalls.
// Reset (rst, synchronous): list empty, head slot zero, no result pending.
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine
// Ordered deque of signed 32-bit values with delete-by-value and search.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     opcode,
  input  logic signed [bole_pkg::DW-1:0] operand,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [bole_pkg::DW-1:0] result_value,
  output logic                           found,
  output logic [1:0]                     status,
  output logic [4:0]                     entry_count
);
  import bole_pkg::*;

  cmd_t       cmd;
  dp_status_t st;

  bole_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  bole_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .opcode       (opcode),
    .operand      (operand),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .found        (found),
    .status       (status),
    .entry_count  (entry_count)
  );

endmodule

// File: sv/bole_ctrl.sv
// ----------------------------------------------------------------------------
// bole_ctrl
// Sequencer for the list engine: steps each operation through execute,
// read, scan and compaction, and hands the result to the output register.
// ----------------------------------------------------------------------------
`include "bounded_ordered_list_engine_assert.svh"

module bole_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bole_pkg::dp_status_t st,
  output bole_pkg::cmd_t      cmd
);
  import bole_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_HEAD;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        unique case (st.op)
          OP_PUSH_TAIL: begin
            if (st.full) cmd.set_full = 1'b1;
            else cmd.push_tail = 1'b1;
          end
          OP_PUSH_HEAD: begin
            if (st.full) cmd.set_full = 1'b1;
            else cmd.push_head = 1'b1;
          end
          OP_POP_HEAD: begin
            if (st.empty) cmd.set_empty = 1'b1;
            else begin
              cmd.rd_sel = RD_HEAD;
              state_next = S_POP;
            end
          end
          OP_POP_TAIL: begin
            if (st.empty) cmd.set_empty = 1'b1;
            else begin
              cmd.rd_sel = RD_TAIL;
              state_next = S_POP;
            end
          end
          OP_DELETE, OP_CONTAINS: begin
            if (!st.empty) begin
              cmd.pos_clr = 1'b1;
              cmd.rd_sel  = RD_HEAD;
              state_next  = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_POP: begin
        if (st.op == OP_POP_HEAD) cmd.pop_head = 1'b1;
        else cmd.pop_tail = 1'b1;
        state_next = S_DONE;
      end
      S_SCAN: begin
        if (st.match) begin
          cmd.set_found = 1'b1;
          state_next    = S_DONE;
          if (st.op == OP_DELETE) begin
            if (st.pos_zero) begin
              cmd.drop_head = 1'b1;
            end else if (st.scan_last) begin
              cmd.occ_dec = 1'b1;
            end else begin
              cmd.rd_sel = RD_NEXT;
              state_next = S_MOVE;
            end
          end
        end else if (st.scan_last) begin
          state_next = S_DONE;
        end else begin
          cmd.pos_inc = 1'b1;
          cmd.rd_sel  = RD_NEXT;
        end
      end
      S_MOVE: begin
        cmd.move_wr = 1'b1;
        if (st.move_last) begin
          cmd.occ_dec = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.pos_inc = 1'b1;
          cmd.rd_sel  = RD_NEXT2;
        end
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `BOLE_ASSERT_IMP(a_pop_nonempty, cmd.pop_head || cmd.pop_tail, !st.empty, "pop on empty list")
  `BOLE_ASSERT_IMP(a_push_room, cmd.push_head || cmd.push_tail, !st.full, "push on full list")
  `BOLE_ASSERT_NEXT(a_load_then_exec, cmd.load, state == S_EXEC, "accepted item not executed")
  `BOLE_ASSERT_IMP(a_out_free, cmd.out_load, !st.out_busy, "result overwrites pending transfer")

endmodule

// File: sv/bole_dp.sv
// ----------------------------------------------------------------------------
// bole_dp
// Datapath of the list engine: ring store, head slot, count, scan position,
// working result and the output register.
// ----------------------------------------------------------------------------
`include "bounded_ordered_list_engine_assert.svh"

module bole_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [2:0]                  opcode,
  input  logic signed [bole_pkg::DW-1:0] operand,
  input  bole_pkg::cmd_t              cmd,
  output bole_pkg::dp_status_t        st,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [bole_pkg::DW-1:0] result_value,
  output logic                        found,
  output logic [1:0]                  status,
  output logic [4:0]                  entry_count
);
  import bole_pkg::*;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic          wr_en;
  logic [SW-1:0] rd_ofs;

  logic [AW-1:0] first_slot;
  logic [CW-1:0] occupancy;
  logic [CW-1:0] pos;
  logic [2:0]    op;
  logic [DW-1:0] key;
  logic [DW-1:0] res_value;
  logic          res_found;
  status_t       res_status;

  logic [DW-1:0] out_value;
  logic          out_found;
  status_t       out_status;
  logic [CW-1:0] out_count;

  logic [AW-1:0] first_dec;
  logic [AW-1:0] first_inc;

  assign first_dec = (first_slot == '0) ? AW'(DEPTH - 1) : first_slot - AW'(1);
  assign first_inc = slot_of(first_slot, SW'(1));

  always_comb begin
    unique case (cmd.rd_sel)
      RD_HEAD:  rd_ofs = '0;
      RD_TAIL:  rd_ofs = SW'(occupancy) - SW'(1);
      RD_NEXT:  rd_ofs = SW'(pos) + SW'(1);
      RD_NEXT2: rd_ofs = SW'(pos) + SW'(2);
      default:  rd_ofs = '0;
    endcase
  end

  assign rd_addr = slot_of(first_slot, rd_ofs);

  always_comb begin
    wr_en   = cmd.push_tail | cmd.push_head | cmd.move_wr;
    wr_addr = slot_of(first_slot, SW'(pos));
    wr_data = rd_data;
    priority if (cmd.push_tail) begin
      wr_addr = slot_of(first_slot, SW'(occupancy));
      wr_data = key;
    end else if (cmd.push_head) begin
      wr_addr = first_dec;
      wr_data = key;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_slot <= '0;
      occupancy  <= '0;
    end else begin
      if (cmd.push_tail) begin
        occupancy <= occupancy + CW'(1);
      end
      if (cmd.push_head) begin
        first_slot <= first_dec;
        occupancy  <= occupancy + CW'(1);
      end
      if (cmd.pop_head || cmd.drop_head) begin
        first_slot <= first_inc;
        occupancy  <= occupancy - CW'(1);
      end
      if (cmd.pop_tail || cmd.occ_dec) begin
        occupancy <= occupancy - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op         <= opcode;
      key        <= operand;
      res_value  <= '0;
      res_found  <= 1'b0;
      res_status <= ST_OK;
    end
    if (cmd.pos_clr) begin
      pos <= '0;
    end else if (cmd.pos_inc) begin
      pos <= pos + CW'(1);
    end
    if (cmd.pop_head || cmd.pop_tail) begin
      res_value <= rd_data;
    end
    if (cmd.set_found) begin
      res_found <= 1'b1;
    end
    if (cmd.set_full) begin
      res_status <= ST_FULL;
    end
    if (cmd.set_empty) begin
      res_status <= ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value  <= res_value;
      out_found  <= res_found;
      out_status <= res_status;
      out_count  <= occupancy;
    end
  end

  assign result_value = out_value;
  assign found        = out_found;
  assign status       = out_status;
  assign entry_count  = 5'(out_count);

  assign st.op        = op;
  assign st.full      = (occupancy == CW'(DEPTH));
  assign st.empty     = (occupancy == '0);
  assign st.match     = (rd_data == key);
  assign st.scan_last = (SW'(pos) + SW'(1)) >= SW'(occupancy);
  assign st.move_last = (SW'(pos) + SW'(2)) >= SW'(occupancy);
  assign st.pos_zero  = (pos == '0);
  assign st.out_busy  = out_valid & out_stall;

  `BOLE_ASSERT_IMP(a_occ_bound, 1'b1, occupancy <= CW'(DEPTH), "count above depth")
  `BOLE_ASSERT_NEXT(a_push_grows, cmd.push_tail || cmd.push_head, occupancy == $past(occupancy) + CW'(1), "push did not grow list")
  `BOLE_ASSERT_NEXT(a_move_keeps_head, cmd.move_wr, first_slot == $past(first_slot), "compaction moved head")

endmodule
